@@ rtl/csr_spmv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector product package
// Field widths, command codes, arithmetic bounds and the item type passed
// from the input stage to the multiply-accumulate datapath.
// ----------------------------------------------------------------------------
package csr_spmv_pkg;

    localparam int CMD_W   = 2;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int ROW_W   = 16;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 2 * VALUE_W;
    localparam int ACC_W   = PROD_W - FRAC_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_NONZERO = 2'd1,
        CMD_EMPTY   = 2'd2
    } cmd_t;

    localparam logic signed [ACC_W-1:0]   ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]   ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] SUM_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] SUM_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic                      row_end;
        logic signed [VALUE_W-1:0] value;
        logic                      in_range;
    } op_t;

endpackage
`default_nettype wire

@@ rtl/csr_spmv_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector product channels
// Valid/ready channels for input items and row results.
// ----------------------------------------------------------------------------
interface csr_spmv_in_if;
    logic                                       valid;
    logic                                       ready;
    logic [csr_spmv_pkg::CMD_W-1:0]             command;
    logic [csr_spmv_pkg::INDEX_W-1:0]           index;
    logic signed [csr_spmv_pkg::VALUE_W-1:0]    value;
    logic                                       row_end;

    modport source (output valid, command, index, value, row_end, input ready);
    modport sink   (input valid, command, index, value, row_end, output ready);
endinterface

interface csr_spmv_out_if;
    logic                                       valid;
    logic                                       ready;
    logic [csr_spmv_pkg::ROW_W-1:0]             row_number;
    logic signed [csr_spmv_pkg::VALUE_W-1:0]    row_sum;
    logic                                       saturated;

    modport source (output valid, row_number, row_sum, saturated, input ready);
    modport sink   (input valid, row_number, row_sum, saturated, output ready);
endinterface
`default_nettype wire

@@ rtl/csr_spmv_vstore.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CSR SpMV vector store
// Single-port-write, single-port-read memory holding the dense vector, with
// registered read data.
// ----------------------------------------------------------------------------
module csr_spmv_vstore #(
    parameter int DEPTH = 1024
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]                wr_addr,
    input  wire logic [csr_spmv_pkg::VALUE_W-1:0]        wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]                rd_addr,
    output logic [csr_spmv_pkg::VALUE_W-1:0]             rd_data
);
    import csr_spmv_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/csr_spmv_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CSR SpMV multiply-accumulate datapath
// Registered product stage, 48-bit saturating accumulator, row counter and
// the result output register.
// ----------------------------------------------------------------------------
module csr_spmv_mac #(
    parameter int MAX_ROWS = 65536
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    op_valid,
    output logic                                         op_ready,
    input  wire csr_spmv_pkg::op_t                       op,
    input  wire logic signed [csr_spmv_pkg::VALUE_W-1:0] entry,
    csr_spmv_out_if.source                               results
);
    import csr_spmv_pkg::*;

    localparam int RC_W = $clog2(MAX_ROWS);

    logic                       s2_valid_reg;
    logic [CMD_W-1:0]           s2_cmd_reg;
    logic                       s2_row_end_reg;
    logic signed [PROD_W-1:0]   s2_prod_reg;
    logic signed [PROD_W-1:0]   prod_next;

    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic [RC_W-1:0]            row_cnt_reg;
    logic [RC_W-1:0]            row_cnt_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [ROW_W-1:0]           row_number_reg;
    logic signed [VALUE_W-1:0]  row_sum_reg;
    logic signed [VALUE_W-1:0]  row_sum_next;
    logic                       saturated_reg;
    logic                       saturated_next;

    logic                       s2_result;
    logic                       out_en;
    logic                       s2_move;
    logic                       s2_load;
    logic signed [ACC_W-1:0]    prod_q;
    logic signed [ACC_W:0]      acc_sum;
    logic signed [ACC_W-1:0]    acc_sat;
    logic                       fits32;
    logic [RC_W-1:0]            row_cnt_inc;

    assign s2_result = s2_valid_reg
                       && ((s2_cmd_reg == CMD_NONZERO && s2_row_end_reg)
                           || s2_cmd_reg == CMD_EMPTY);
    assign out_en    = !out_valid_reg || results.ready;
    assign s2_move   = s2_valid_reg && (!s2_result || out_en);
    assign s2_load   = !s2_valid_reg || s2_move;
    assign op_ready  = s2_load;

    assign prod_next = op.value * entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            s2_valid_reg <= op_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && op_valid)
        begin
            s2_cmd_reg     <= op.command;
            s2_row_end_reg <= op.row_end;
            s2_prod_reg    <= prod_next;
        end
    end

    // floor shift: drop the low fraction bits
    assign prod_q  = s2_prod_reg[PROD_W-1:FRAC_W];
    assign acc_sum = {acc_reg[ACC_W-1], acc_reg} + {prod_q[ACC_W-1], prod_q};

    always_comb
    begin
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
        begin
            acc_sat = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    assign fits32 = (&acc_sat[ACC_W-1:VALUE_W-1]) || !(|acc_sat[ACC_W-1:VALUE_W-1]);
    assign row_cnt_inc = (row_cnt_reg == RC_W'(MAX_ROWS - 1)) ? '0 : row_cnt_reg + 1'b1;

    always_comb
    begin
        acc_next       = acc_reg;
        row_cnt_next   = row_cnt_reg;
        row_sum_next   = '0;
        saturated_next = 1'b0;
        if (s2_move)
        begin
            case (s2_cmd_reg)
                CMD_LOAD:
                begin
                    row_cnt_next = '0;
                end
                CMD_NONZERO:
                begin
                    if (s2_row_end_reg)
                    begin
                        acc_next     = '0;
                        row_cnt_next = row_cnt_inc;
                        if (fits32)
                        begin
                            row_sum_next = acc_sat[VALUE_W-1:0];
                        end
                        else
                        begin
                            row_sum_next   = acc_sat[ACC_W-1] ? SUM_MIN : SUM_MAX;
                            saturated_next = 1'b1;
                        end
                    end
                    else
                    begin
                        acc_next = acc_sat;
                    end
                end
                CMD_EMPTY:
                begin
                    acc_next     = '0;
                    row_cnt_next = row_cnt_inc;
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        if (out_en)
        begin
            out_valid_next = s2_move && s2_result;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            row_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            row_cnt_reg   <= row_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move && s2_result)
        begin
            row_number_reg <= ROW_W'(row_cnt_reg);
            row_sum_reg    <= row_sum_next;
            saturated_reg  <= saturated_next;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.row_number = row_number_reg;
    assign results.row_sum    = row_sum_reg;
    assign results.saturated  = saturated_reg;

endmodule
`default_nettype wire

@@ rtl/csr_sparse_matrix_vector_product.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A row result passes the input register and vector store read, the product
// register and the result register after the row's last transaction.
// It takes one input transaction per cycle unless results stall; the vector
// store takes one write or one read per cycle. Reset clears the accumulator,
// the row counter and all valid flags; the vector store is not cleared.
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector product
// Streams CSR nonzeros against a stored dense vector in Q16.16 and emits one
// saturated sum per finished row.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_vector_product #(
    parameter int VEC_LEN  = 1024,
    parameter int MAX_ROWS = 65536
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    csr_spmv_in_if.sink     items,
    csr_spmv_out_if.source  results
);
    import csr_spmv_pkg::*;

    localparam int INDEX_SPAN  = 2 ** INDEX_W;
    localparam int STORE_DEPTH = (VEC_LEN < INDEX_SPAN) ? VEC_LEN : INDEX_SPAN;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    logic                       s1_valid_reg;
    op_t                        s1_op_reg;
    logic                       op_ready;
    logic                       accept;
    logic                       in_range;
    logic [ADDR_W-1:0]          addr;
    logic [VALUE_W-1:0]         rd_data;
    logic signed [VALUE_W-1:0]  entry;

    assign items.ready = !s1_valid_reg || op_ready;
    assign accept      = items.valid && items.ready;
    assign in_range    = 32'(items.index) < 32'(VEC_LEN);
    assign addr        = items.index[ADDR_W-1:0];

    csr_spmv_vstore #(
        .DEPTH   (STORE_DEPTH)
    ) u_vstore (
        .clk     (clk),
        .wr_en   (accept && items.command == CMD_LOAD && in_range),
        .wr_addr (addr),
        .wr_data (items.value),
        .rd_en   (accept && items.command == CMD_NONZERO),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (items.ready)
        begin
            s1_valid_reg <= items.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg.command  <= items.command;
            s1_op_reg.row_end  <= items.row_end;
            s1_op_reg.value    <= items.value;
            s1_op_reg.in_range <= in_range;
        end
    end

    // out-of-range column reads as zero
    assign entry = s1_op_reg.in_range ? rd_data : '0;

    csr_spmv_mac #(
        .MAX_ROWS (MAX_ROWS)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (s1_valid_reg),
        .op_ready (op_ready),
        .op       (s1_op_reg),
        .entry    (entry),
        .results  (results)
    );

endmodule
`default_nettype wire

@@ rtl/csr_spmv_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CSR SpMV port checker
// Port-level properties of the top level, attached by bind.
// ----------------------------------------------------------------------------
module csr_spmv_checker (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_ready,
    input  wire logic                                    out_valid,
    input  wire logic                                    out_ready,
    input  wire logic [csr_spmv_pkg::ROW_W-1:0]          row_number,
    input  wire logic signed [csr_spmv_pkg::VALUE_W-1:0] row_sum,
    input  wire logic                                    saturated
);
    import csr_spmv_pkg::*;

    a_reset_no_result: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(row_number)
                                    && $stable(row_sum) && $stable(saturated))
        else $error("stalled result transaction changed");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> row_sum == SUM_MAX || row_sum == SUM_MIN)
        else $error("saturated sum not at a bound");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

bind csr_sparse_matrix_vector_product csr_spmv_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (items.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .row_number (results.row_number),
    .row_sum    (results.row_sum),
    .saturated  (results.saturated)
);
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSR sparse matrix-vector product testbench
// Streams vector loads, CSR nonzeros and empty rows into the block, mirrors
// the Q16.16 multiply-accumulate and the row counter in a local predictor,
// and checks every row result in order. Covers saturation, rounding toward
// minus infinity, loads in the middle of a row, discarded partial sums,
// ignored commands, output back-pressure and back-to-back streaming.
// ----------------------------------------------------------------------------
module tb_top;
    import csr_spmv_pkg::*;

    localparam int VEC_LEN       = 1024;
    localparam int MAX_ROWS      = 65536;
    localparam int RANDOM_ITEMS  = 340;
    localparam int PRESSURE_ROWS = 60;
    localparam int STREAM_ROWS   = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int REPORT_LIMIT  = 40;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] value;
        logic                      row_end;
    } spmv_item_t;

    typedef struct packed {
        logic [ROW_W-1:0]          row_number;
        logic signed [VALUE_W-1:0] row_sum;
        logic                      saturated;
    } row_result_t;

    logic clk;
    logic rst_n;

    csr_spmv_in_if  items_if ();
    csr_spmv_out_if results_if ();

    csr_sparse_matrix_vector_product #(
        .VEC_LEN  (VEC_LEN),
        .MAX_ROWS (MAX_ROWS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if)
    );

    logic signed [VALUE_W-1:0] vector_mirror [VEC_LEN];
    logic signed [ACC_W-1:0]   acc_mirror;
    logic [ROW_W-1:0]          row_mirror;
    bit                        col_loaded [VEC_LEN];
    int                        loaded_cols [$];
    row_result_t               expected_rows [$];

    int  items_sent;
    int  error_count;
    int  cycle_count;
    int  sink_hold_cycles;
    bit  src_idle_on;
    bit  sink_idle_on;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stall bursts plus an optional long hold-off.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        results_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_cycles > 0)
            begin
                results_if.ready <= 1'b0;
                sink_hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                results_if.ready <= 1'b0;
                stall_left--;
            end
            else if (sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                results_if.ready <= 1'b0;
                stall_left = $urandom_range(1, 6) - 1;
            end
            else
            begin
                results_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        row_result_t exp_row;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (expected_rows.size() == 0)
            begin
                if (error_count < REPORT_LIMIT)
                    $display("%0t unexpected result: expected none, actual row %0d sum %h sat %0b",
                             $time, results_if.row_number, results_if.row_sum,
                             results_if.saturated);
                error_count++;
            end
            else
            begin
                exp_row = expected_rows.pop_front();
                if (results_if.row_number !== exp_row.row_number)
                begin
                    if (error_count < REPORT_LIMIT)
                        $display("%0t row_number mismatch: expected %0d, actual %0d",
                                 $time, exp_row.row_number, results_if.row_number);
                    error_count++;
                end
                if (results_if.row_sum !== exp_row.row_sum)
                begin
                    if (error_count < REPORT_LIMIT)
                        $display("%0t row_sum mismatch (row %0d): expected %h, actual %h",
                                 $time, exp_row.row_number, exp_row.row_sum,
                                 results_if.row_sum);
                    error_count++;
                end
                if (results_if.saturated !== exp_row.saturated)
                begin
                    if (error_count < REPORT_LIMIT)
                        $display("%0t saturated mismatch (row %0d): expected %0b, actual %0b",
                                 $time, exp_row.row_number, exp_row.saturated,
                                 results_if.saturated);
                    error_count++;
                end
            end
        end
    end

    task automatic predict_row_sum(input spmv_item_t it);
        logic signed [63:0] wide_value;
        logic signed [63:0] wide_entry;
        logic signed [63:0] product;
        logic signed [63:0] total;
        row_result_t        res;
        case (it.command)
            CMD_LOAD:
            begin
                if (it.index < VEC_LEN)
                    vector_mirror[it.index] = it.value;
                row_mirror = '0;
            end
            CMD_NONZERO:
            begin
                wide_value = it.value;
                if (it.index < VEC_LEN)
                    wide_entry = vector_mirror[it.index];
                else
                    wide_entry = 64'sd0;
                product = wide_value * wide_entry;
                total   = acc_mirror + (product >>> FRAC_W);
                if (total > ACC_MAX)
                    total = ACC_MAX;
                if (total < ACC_MIN)
                    total = ACC_MIN;
                acc_mirror = total[ACC_W-1:0];
                if (it.row_end)
                begin
                    res.row_number = row_mirror;
                    res.saturated  = 1'b0;
                    if (acc_mirror > SUM_MAX)
                    begin
                        res.row_sum   = SUM_MAX;
                        res.saturated = 1'b1;
                    end
                    else if (acc_mirror < SUM_MIN)
                    begin
                        res.row_sum   = SUM_MIN;
                        res.saturated = 1'b1;
                    end
                    else
                    begin
                        res.row_sum = acc_mirror[VALUE_W-1:0];
                    end
                    expected_rows.push_back(res);
                    acc_mirror = '0;
                    row_mirror = row_mirror + 1'b1;
                end
            end
            CMD_EMPTY:
            begin
                res.row_number = row_mirror;
                res.row_sum    = '0;
                res.saturated  = 1'b0;
                expected_rows.push_back(res);
                acc_mirror = '0;
                row_mirror = row_mirror + 1'b1;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_item(input spmv_item_t it);
        int gap;
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                items_if.valid <= 1'b0;
            end
        end
        @(negedge clk);
        items_if.valid   <= 1'b1;
        items_if.command <= it.command;
        items_if.index   <= it.index;
        items_if.value   <= it.value;
        items_if.row_end <= it.row_end;
        @(posedge clk);
        while (!items_if.ready)
            @(posedge clk);
        predict_row_sum(it);
        if (it.command == CMD_LOAD && !col_loaded[it.index])
        begin
            col_loaded[it.index] = 1'b1;
            loaded_cols.push_back(it.index);
        end
        if (it.command != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic send(input logic [CMD_W-1:0] command, input int index,
                        input logic [VALUE_W-1:0] value, input logic row_end);
        spmv_item_t it;
        it.command = command;
        it.index   = index[INDEX_W-1:0];
        it.value   = value;
        it.row_end = row_end;
        send_item(it);
    endtask

    function automatic logic [VALUE_W-1:0] random_q16();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 6)
            return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        else if (mode < 8)
            return $urandom;
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0000_0001;
            default: return 32'h0001_0000;
        endcase
    endfunction

    function automatic int loaded_col();
        return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
    endfunction

    task automatic load_entries(input int count);
        repeat (count)
            send(CMD_LOAD, $urandom_range(0, VEC_LEN - 1), random_q16(),
                 1'($urandom_range(0, 1)));
    endtask

    task automatic send_row(input int len, input bit mid_load);
        for (int k = 0; k < len; k++)
        begin
            if (mid_load && k == len / 2)
                load_entries(1);
            send(CMD_NONZERO, loaded_col(), random_q16(), k == len - 1);
        end
    endtask

    task automatic send_empty_row();
        send(CMD_EMPTY, $urandom_range(0, VEC_LEN - 1), $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic test_directed();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send(CMD_LOAD, 0, 32'h0001_0000, 1'b0);
        send(CMD_LOAD, VEC_LEN - 1, 32'h7FFF_FFFF, 1'b0);
        send(CMD_LOAD, 1, 32'h8000_0000, 1'b0);
        send(CMD_LOAD, 2, 32'hFFFF_FFFF, 1'b0);
        send(CMD_NONZERO, 0, 32'h0002_0000, 1'b0);
        send(CMD_NONZERO, 2, 32'h0000_0001, 1'b1);
        send(CMD_EMPTY, 0, 32'h0000_0000, 1'b1);
        repeat (2)
            send(CMD_NONZERO, 1, 32'h8000_0000, 1'b0);
        send(CMD_NONZERO, 1, 32'h8000_0000, 1'b1);
        repeat (2)
            send(CMD_NONZERO, 1, 32'h7FFF_FFFF, 1'b0);
        send(CMD_NONZERO, 1, 32'h7FFF_FFFF, 1'b1);
        send(CMD_NONZERO, VEC_LEN - 1, 32'h7FFF_FFFF, 1'b1);
        send(CMD_NONZERO, 0, 32'h0003_0000, 1'b0);
        send(CMD_LOAD, 5, 32'h0000_8000, 1'b1);
        send(CMD_NONZERO, 5, 32'h0004_0000, 1'b1);
        send(CMD_NONZERO, 0, 32'hFFFF_0000, 1'b0);
        send(CMD_EMPTY, VEC_LEN - 1, 32'hFFFF_FFFF, 1'b0);
        send(CMD_UNUSED, VEC_LEN - 1, 32'hFFFF_FFFF, 1'b1);
        send(CMD_NONZERO, 0, 32'h8000_0000, 1'b1);
        send(CMD_NONZERO, VEC_LEN - 1, 32'h0000_0000, 1'b1);
    endtask

    task automatic test_random_rows();
        int first_item;
        int kind;
        first_item   = items_sent;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        while (items_sent - first_item < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 12)
                load_entries($urandom_range(1, 4));
            else if (kind < 72)
                send_row($urandom_range(1, 6), 1'b0);
            else if (kind < 82)
                send_empty_row();
            else if (kind < 88)
                send_row($urandom_range(2, 6), 1'b1);
            else if (kind < 94)
            begin
                repeat ($urandom_range(1, 3))
                    send(CMD_NONZERO, loaded_col(), random_q16(), 1'b0);
                send_empty_row();
            end
            else
                send(CMD_UNUSED, $urandom_range(0, VEC_LEN - 1), $urandom,
                     1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_backpressure();
        src_idle_on      = 1'b0;
        sink_idle_on     = 1'b1;
        sink_hold_cycles = HOLD_CYCLES;
        repeat (PRESSURE_ROWS)
        begin
            if ($urandom_range(0, 1) == 0)
                send_empty_row();
            else
                send_row($urandom_range(1, 3), 1'b0);
        end
    endtask

    task automatic test_streaming();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        load_entries(2);
        repeat (STREAM_ROWS)
        begin
            if ($urandom_range(0, 4) == 0)
                send_empty_row();
            else
                send_row($urandom_range(1, 4), 1'b0);
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        items_if.valid   = 1'b0;
        items_if.command = CMD_LOAD;
        items_if.index   = '0;
        items_if.value   = '0;
        items_if.row_end = 1'b0;
        acc_mirror       = '0;
        row_mirror       = '0;
        items_sent       = 0;
        error_count      = 0;
        cycle_count      = 0;
        sink_hold_cycles = 0;
        src_idle_on      = 1'b0;
        sink_idle_on     = 1'b0;
        for (int i = 0; i < VEC_LEN; i++)
        begin
            vector_mirror[i] = '0;
            col_loaded[i]    = 1'b0;
        end
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_rows();
        test_backpressure();
        test_streaming();

        @(negedge clk);
        items_if.valid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (error_count == 0 && expected_rows.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/csr_spmv_pkg.sv
rtl/csr_spmv_if.sv
rtl/csr_spmv_vstore.sv
rtl/csr_spmv_mac.sv
rtl/csr_sparse_matrix_vector_product.sv
rtl/csr_spmv_checker.sv
tb/tb_top.sv
